// ----- hdl/rlu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlu_pkg: shared types and constants of the IPv4 route lookup core
// Table geometry, verdict codes, stored route entry and result formats.
// ----------------------------------------------------------------------------
package rlu_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int LEN_W       = 6;
  localparam logic [LEN_W-1:0] LEN_MAX = 6'd32;

  typedef enum logic [2:0] {
    VERDICT_ADDED    = 3'd0,
    VERDICT_FULL     = 3'd1,
    VERDICT_TTL      = 3'd2,
    VERDICT_DIRECT   = 3'd3,
    VERDICT_INDIRECT = 3'd4,
    VERDICT_NOROUTE  = 3'd5
  } verdict_t;

  typedef struct packed {
    logic [31:0]      prefix;
    logic [LEN_W-1:0] len;
    logic             direct;
    logic [31:0]      hop;
  } route_entry_t;

  typedef struct packed {
    verdict_t         verdict;
    logic [31:0]      hop;
    logic [LEN_W-1:0] len;
  } result_t;

  localparam int ENTRY_W = $bits(route_entry_t);

  // Leading len bits set; stored lengths never exceed 32.
  function automatic logic [31:0] mask_of(input logic [LEN_W-1:0] len);
    logic [31:0] m;
    if (len >= LEN_MAX) begin
      m = 32'hFFFF_FFFF;
    end else begin
      m = ~(32'hFFFF_FFFF >> len);
    end
    return m;
  endfunction

endpackage

// ----- hdl/rlu_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlu_in_if / rlu_out_if: valid/ready channels of the route lookup core
// Command channel into the core and result channel out of it.
// ----------------------------------------------------------------------------
interface rlu_in_if;
  logic        valid;
  logic        ready;
  logic        cmd;
  logic [31:0] route_prefix;
  logic [5:0]  prefix_len;
  logic        route_is_direct;
  logic [31:0] route_next_hop;
  logic [31:0] dest_ip;
  logic [7:0]  ttl;

  modport source (
    output valid, cmd, route_prefix, prefix_len, route_is_direct, route_next_hop,
           dest_ip, ttl,
    input  ready
  );
  modport sink (
    input  valid, cmd, route_prefix, prefix_len, route_is_direct, route_next_hop,
           dest_ip, ttl,
    output ready
  );
endinterface

interface rlu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  verdict;
  logic [31:0] hop_address;
  logic [5:0]  matched_len;

  modport source (output valid, verdict, hop_address, matched_len, input ready);
  modport sink   (input  valid, verdict, hop_address, matched_len, output ready);
endinterface

// ----- hdl/rlu_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlu_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module rlu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                          clk,
  input  logic                                          we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  waddr,
  input  logic [WIDTH-1:0]                              wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]  raddr,
  output logic [WIDTH-1:0]                              rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/ipv4_route_lookup_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ipv4_route_lookup_core: route table lookup, direct routes first, else longest indirect prefix
// Appends routes to a table RAM and scans it to resolve packet destinations.
// ----------------------------------------------------------------------------
//
//  channel  | direction | carries
//  ---------+-----------+------------------------------------------------------
//  in_ch    | sink      | cmd, route fields (add) or dest_ip and ttl (lookup)
//  out_ch   | source    | verdict, hop_address, matched_len (one per command)
//
//  Sequence: an add, a TTL-expired lookup or a lookup on an empty table goes
//  from acceptance to S_DONE and then the output register; a lookup first
//  walks the N stored routes in S_SCAN through the single RAM read port, one
//  entry per cycle, before S_DONE. Commands are taken one at a time.
//  Reset clears the control state, the entry count and the output valid; the
//  table RAM needs no clearing pass, since no entry at or above the count is
//  ever used in a match.
//  A result waits in the output register while out_ch stalls; a finished
//  result behind it holds the core until that register drains.
//
module ipv4_route_lookup_core (
  input  logic         clk,
  input  logic         rst_n,
  rlu_in_if.sink       in_ch,
  rlu_out_if.source    out_ch
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Control state
  state_t                    state_r, state_nxt;
  logic [rlu_pkg::CNT_W-1:0] count_r, count_nxt;
  logic                      out_valid_r, out_valid_nxt;

  // Payload state
  logic [rlu_pkg::CNT_W-1:0] scan_idx_r, scan_idx_nxt;
  logic [31:0]               dest_r, dest_nxt;
  logic                      dir_found_r, dir_found_nxt;
  logic [rlu_pkg::LEN_W-1:0] dir_len_r, dir_len_nxt;
  logic                      ind_found_r, ind_found_nxt;
  logic [rlu_pkg::LEN_W-1:0] ind_len_r, ind_len_nxt;
  logic [31:0]               ind_hop_r, ind_hop_nxt;
  rlu_pkg::result_t          res_r, res_nxt;
  rlu_pkg::result_t          out_res_r, out_res_nxt;

  // Table RAM ports
  logic                         ram_we;
  logic [rlu_pkg::ADDR_W-1:0]   ram_waddr;
  rlu_pkg::route_entry_t        ram_wentry;
  logic [rlu_pkg::ADDR_W-1:0]   ram_raddr;
  logic [rlu_pkg::ENTRY_W-1:0]  ram_rdata;
  rlu_pkg::route_entry_t        entry;

  logic                       in_fire;
  logic                       out_free;
  logic                       entry_hit;
  logic                       last_entry;
  logic [rlu_pkg::CNT_W-1:0]  scan_idx_inc;
  logic [rlu_pkg::LEN_W-1:0]  add_len;

  rlu_ram #(
    .WIDTH (rlu_pkg::ENTRY_W),
    .DEPTH (rlu_pkg::TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wentry),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign entry = rlu_pkg::route_entry_t'(ram_rdata);

  // Accept a new command only between commands.
  assign in_ch.ready = (state_r == S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid_r || out_ch.ready;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.verdict     = out_res_r.verdict;
  assign out_ch.hop_address = out_res_r.hop;
  assign out_ch.matched_len = out_res_r.len;

  // Saturate an oversized prefix length to a host route.
  assign add_len = (in_ch.prefix_len > rlu_pkg::LEN_MAX) ? rlu_pkg::LEN_MAX
                                                         : in_ch.prefix_len;

  // Entry under test arrives from the registered RAM read, the cycle after its address went out.
  assign entry_hit    = (entry.prefix == (dest_r & rlu_pkg::mask_of(entry.len)));
  assign scan_idx_inc = scan_idx_r + 1'b1;
  assign last_entry   = (scan_idx_r == (count_r - 1'b1));

  // Walk the table: entry zero is read on acceptance, the next one each
  // scan cycle.
  assign ram_raddr = (state_r == S_SCAN) ? scan_idx_inc[rlu_pkg::ADDR_W-1:0] : '0;

  // Append at the current count.
  assign ram_waddr         = count_r[rlu_pkg::ADDR_W-1:0];
  assign ram_wentry.prefix = in_ch.route_prefix;
  assign ram_wentry.len    = add_len;
  assign ram_wentry.direct = in_ch.route_is_direct;
  assign ram_wentry.hop    = in_ch.route_next_hop;

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    scan_idx_nxt  = scan_idx_r;
    dest_nxt      = dest_r;
    dir_found_nxt = dir_found_r;
    dir_len_nxt   = dir_len_r;
    ind_found_nxt = ind_found_r;
    ind_len_nxt   = ind_len_r;
    ind_hop_nxt   = ind_hop_r;
    res_nxt       = res_r;
    out_res_nxt   = out_res_r;
    ram_we        = 1'b0;

    // Drop the output transaction once taken.
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          res_nxt.hop = '0;
          res_nxt.len = '0;
          if (!in_ch.cmd) begin
            if (count_r == rlu_pkg::CNT_W'(rlu_pkg::TABLE_DEPTH)) begin
              res_nxt.verdict = rlu_pkg::VERDICT_FULL;
            end else begin
              ram_we          = 1'b1;
              count_nxt       = count_r + 1'b1;
              res_nxt.verdict = rlu_pkg::VERDICT_ADDED;
            end
            state_nxt = S_DONE;
          end else if (in_ch.ttl == 8'd0) begin
            res_nxt.verdict = rlu_pkg::VERDICT_TTL;
            state_nxt       = S_DONE;
          end else if (count_r == '0) begin
            res_nxt.verdict = rlu_pkg::VERDICT_NOROUTE;
            state_nxt       = S_DONE;
          end else begin
            dest_nxt      = in_ch.dest_ip;
            scan_idx_nxt  = '0;
            dir_found_nxt = 1'b0;
            ind_found_nxt = 1'b0;
            state_nxt     = S_SCAN;
          end
        end
      end

      S_SCAN: begin
        // First direct hit wins outright; among indirect hits keep the
        // strictly longer one so that the earlier entry wins ties.
        if (entry_hit && entry.direct && !dir_found_r) begin
          dir_found_nxt = 1'b1;
          dir_len_nxt   = entry.len;
        end
        if (entry_hit && !entry.direct && (!ind_found_r || entry.len > ind_len_r)) begin
          ind_found_nxt = 1'b1;
          ind_len_nxt   = entry.len;
          ind_hop_nxt   = entry.hop;
        end
        scan_idx_nxt = scan_idx_inc;
        if (last_entry) begin
          if (dir_found_nxt) begin
            res_nxt.verdict = rlu_pkg::VERDICT_DIRECT;
            res_nxt.hop     = '0;
            res_nxt.len     = dir_len_nxt;
          end else if (ind_found_nxt) begin
            res_nxt.verdict = rlu_pkg::VERDICT_INDIRECT;
            res_nxt.hop     = ind_hop_nxt;
            res_nxt.len     = ind_len_nxt;
          end else begin
            res_nxt.verdict = rlu_pkg::VERDICT_NOROUTE;
            res_nxt.hop     = '0;
            res_nxt.len     = '0;
          end
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        // Hold the result until the output register is free.
        if (out_free) begin
          out_res_nxt   = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    scan_idx_r  <= scan_idx_nxt;
    dest_r      <= dest_nxt;
    dir_found_r <= dir_found_nxt;
    dir_len_r   <= dir_len_nxt;
    ind_found_r <= ind_found_nxt;
    ind_len_r   <= ind_len_nxt;
    ind_hop_r   <= ind_hop_nxt;
    res_r       <= res_nxt;
    out_res_r   <= out_res_nxt;
  end

endmodule
